FILE: rtl/atan2ti_pkg.sv
// shared constants, control types and the arctangent table for the atan2 block
// no dependencies; used by the interfaces, the cells and the top level
package atan2ti_pkg;

  localparam int COORD_W         = 32;
  localparam int ANGLE_W         = 12;
  localparam int INPUT_WIDTH_DEF = 32;
  localparam int TABLE_STEPS_DEF = 32;
  localparam int DEN_W           = 18;
  localparam int FRAC_W          = 8;
  localparam int TBL_LEN         = 33;
  localparam int IDX_W           = 7;
  localparam int ENTRY_W         = 9;
  localparam int DIFF_W          = 4;
  localparam int QUARTER_TURN    = 512;
  localparam int HALF_TURN       = 1024;

  typedef struct packed {
    logic zero;
    logic steep;
    logic xneg;
    logic yneg;
  } fold_t;

  typedef struct packed {
    logic  valid;
    fold_t fold;
  } ctrl_t;

  // round(1024 * atan(i / 32) / pi)
  function automatic logic [ENTRY_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
    logic [ENTRY_W-1:0] e;
    case (i)
      7'd0:    e = 9'd0;
      7'd1:    e = 9'd10;
      7'd2:    e = 9'd20;
      7'd3:    e = 9'd30;
      7'd4:    e = 9'd41;
      7'd5:    e = 9'd51;
      7'd6:    e = 9'd60;
      7'd7:    e = 9'd70;
      7'd8:    e = 9'd80;
      7'd9:    e = 9'd89;
      7'd10:   e = 9'd99;
      7'd11:   e = 9'd108;
      7'd12:   e = 9'd117;
      7'd13:   e = 9'd126;
      7'd14:   e = 9'd134;
      7'd15:   e = 9'd143;
      7'd16:   e = 9'd151;
      7'd17:   e = 9'd159;
      7'd18:   e = 9'd167;
      7'd19:   e = 9'd175;
      7'd20:   e = 9'd182;
      7'd21:   e = 9'd189;
      7'd22:   e = 9'd196;
      7'd23:   e = 9'd203;
      7'd24:   e = 9'd210;
      7'd25:   e = 9'd216;
      7'd26:   e = 9'd222;
      7'd27:   e = 9'd228;
      7'd28:   e = 9'd234;
      7'd29:   e = 9'd240;
      7'd30:   e = 9'd245;
      7'd31:   e = 9'd251;
      default: e = 9'd256;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/atan2ti_in_if.sv
// input channel of the atan2 block: coordinate pair with valid/ready
// depends on atan2ti_pkg
interface atan2ti_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [atan2ti_pkg::COORD_W-1:0]   y_coord;
  logic signed [atan2ti_pkg::COORD_W-1:0]   x_coord;

  modport source(output valid, y_coord, x_coord, input ready);
  modport sink(input valid, y_coord, x_coord, output ready);
endinterface

FILE: rtl/atan2ti_out_if.sv
// result channel of the atan2 block: angle with valid/ready
// depends on atan2ti_pkg
interface atan2ti_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [atan2ti_pkg::ANGLE_W-1:0]   angle;

  modport source(output valid, angle, input ready);
  modport sink(input valid, angle, output ready);
endinterface

FILE: rtl/atan2ti_norm_cell.sv
// operand scaling cell: shifts numerator and denominator right by SHIFT
// when the denominator is still too large; depends on atan2ti_pkg
module atan2ti_norm_cell #(
  parameter int MAG_W = 31,
  parameter int SHIFT = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  atan2ti_pkg::ctrl_t ctrl_i,
  input  logic [MAG_W-1:0]   num_i,
  input  logic [MAG_W-1:0]   den_i,
  output atan2ti_pkg::ctrl_t ctrl_o,
  output logic [MAG_W-1:0]   num_o,
  output logic [MAG_W-1:0]   den_o
);

  localparam int LIM_BIT = atan2ti_pkg::DEN_W - 1 + SHIFT;

  atan2ti_pkg::ctrl_t ctrl_r;
  logic [MAG_W-1:0]   num_r;
  logic [MAG_W-1:0]   den_r;
  logic [MAG_W-1:0]   num_nxt;
  logic [MAG_W-1:0]   den_nxt;
  logic               big;

  assign big     = |den_i[MAG_W-1:LIM_BIT];
  assign num_nxt = big ? (num_i >> SHIFT) : num_i;
  assign den_nxt = big ? (den_i >> SHIFT) : den_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (adv) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign ctrl_o = ctrl_r;
  assign num_o  = num_r;
  assign den_o  = den_r;

endmodule

FILE: rtl/atan2ti_div_cell.sv
// restoring division cell: one quotient bit per cell, remainder handed on
// depends on atan2ti_pkg
module atan2ti_div_cell #(
  parameter int QUO_W = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  atan2ti_pkg::ctrl_t              ctrl_i,
  input  logic [atan2ti_pkg::DEN_W-1:0]   rem_i,
  input  logic [QUO_W-1:0]                low_i,
  input  logic [QUO_W-1:0]                quo_i,
  input  logic [atan2ti_pkg::DEN_W-1:0]   den_i,
  output atan2ti_pkg::ctrl_t              ctrl_o,
  output logic [atan2ti_pkg::DEN_W-1:0]   rem_o,
  output logic [QUO_W-1:0]                low_o,
  output logic [QUO_W-1:0]                quo_o,
  output logic [atan2ti_pkg::DEN_W-1:0]   den_o
);

  localparam int DW = atan2ti_pkg::DEN_W;

  atan2ti_pkg::ctrl_t ctrl_r;
  logic [DW-1:0]      rem_r;
  logic [QUO_W-1:0]   low_r;
  logic [QUO_W-1:0]   quo_r;
  logic [DW-1:0]      den_r;
  logic [DW:0]        trial;
  logic [DW:0]        sub;
  logic               fits;
  logic [DW-1:0]      rem_nxt;
  logic [QUO_W-1:0]   low_nxt;
  logic [QUO_W-1:0]   quo_nxt;

  assign trial   = {rem_i, low_i[QUO_W-1]};
  assign fits    = trial >= {1'b0, den_i};
  assign sub     = trial - {1'b0, den_i};
  assign rem_nxt = fits ? sub[DW-1:0] : trial[DW-1:0];
  assign low_nxt = {low_i[QUO_W-2:0], 1'b0};
  assign quo_nxt = {quo_i[QUO_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (adv) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
      den_r <= den_i;
    end
  end

  assign ctrl_o = ctrl_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;

endmodule

FILE: rtl/atan2_table_interpolated_top.sv
// atan2 block top level: magnitude stage, scaling cells, divider cells,
// table lookup and octant folding; depends on atan2ti_pkg, both interfaces
// and the norm and div cells
//
// usage: in_if carries a signed pair (y_coord, x_coord), out_if returns
// angle, signed, 1024 = pi. items move on valid && ready on both channels.
// only the low INPUT_WIDTH bits of each coordinate count.
// the pipeline takes one item per cycle while out_if does not stall it.
// between input accept and out_if.valid lie the magnitude and octant
// stages, S scaling cells (4 at INPUT_WIDTH 32), the multiply stage,
// Q divider cells of one quotient bit each (Q = 14 at TABLE_STEPS 32),
// the lookup and output stages; the divider chain sets the depth.
// when out_if.ready is low with a result waiting the whole pipeline
// holds and in_if.ready drops; nothing is lost or repeated.
// synchronous reset clears all valid flags; no item is in flight after it.
module atan2_table_interpolated_top #(
  parameter int INPUT_WIDTH = atan2ti_pkg::INPUT_WIDTH_DEF,
  parameter int TABLE_STEPS = atan2ti_pkg::TABLE_STEPS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  atan2ti_in_if.sink    in_if,
  atan2ti_out_if.source out_if
);

  localparam int MAG_W     = INPUT_WIDTH - 1;
  localparam int DW        = atan2ti_pkg::DEN_W;
  localparam int FW        = atan2ti_pkg::FRAC_W;
  localparam int EW        = atan2ti_pkg::ENTRY_W;
  localparam int AW        = atan2ti_pkg::ANGLE_W;
  localparam int MAX_SHIFT = (MAG_W > DW) ? MAG_W - DW : 0;
  localparam int NORM_N    = (MAX_SHIFT > 0) ? $clog2(MAX_SHIFT + 1) : 0;
  localparam int SCALE     = TABLE_STEPS * (1 << FW);
  localparam int QUO_W     = $clog2(SCALE + 1);
  localparam int PROD_W    = DW + QUO_W;
  localparam int IDXQ_W    = QUO_W - FW;
  localparam int LAST_IDX  = (TABLE_STEPS < atan2ti_pkg::TBL_LEN - 1) ?
                             TABLE_STEPS : atan2ti_pkg::TBL_LEN - 1;

  logic adv;

  // magnitude stage
  logic [INPUT_WIDTH-1:0] y_in, x_in;
  logic [MAG_W-1:0]       y_low, x_low, y_mag, x_mag;
  logic                   y_neg, x_neg;
  atan2ti_pkg::ctrl_t     s0_ctrl_nxt, s0_ctrl_r;
  logic [MAG_W-1:0]       s0_ax_r, s0_ay_r;

  assign y_in  = in_if.y_coord[INPUT_WIDTH-1:0];
  assign x_in  = in_if.x_coord[INPUT_WIDTH-1:0];
  assign y_neg = y_in[INPUT_WIDTH-1];
  assign x_neg = x_in[INPUT_WIDTH-1];
  assign y_low = y_in[MAG_W-1:0];
  assign x_low = x_in[MAG_W-1:0];
  // most negative value clamps to all ones
  assign y_mag = !y_neg ? y_low : ((y_low == '0) ? '1 : MAG_W'(~y_low + 1'b1));
  assign x_mag = !x_neg ? x_low : ((x_low == '0) ? '1 : MAG_W'(~x_low + 1'b1));

  always_comb begin
    s0_ctrl_nxt            = '0;
    s0_ctrl_nxt.valid      = in_if.valid;
    s0_ctrl_nxt.fold.zero  = (y_mag == '0) && (x_mag == '0);
    s0_ctrl_nxt.fold.xneg  = x_neg;
    s0_ctrl_nxt.fold.yneg  = y_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctrl_r <= '0;
    end else if (adv) begin
      s0_ctrl_r <= s0_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ax_r <= x_mag;
      s0_ay_r <= y_mag;
    end
  end

  // octant select stage
  logic               steep;
  atan2ti_pkg::ctrl_t s1_ctrl_nxt, s1_ctrl_r;
  logic [MAG_W-1:0]   s1_num_r, s1_den_r;

  assign steep = s0_ay_r > s0_ax_r;

  always_comb begin
    s1_ctrl_nxt            = s0_ctrl_r;
    s1_ctrl_nxt.fold.steep = steep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r <= s1_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num_r <= steep ? s0_ax_r : s0_ay_r;
      s1_den_r <= steep ? s0_ay_r : s0_ax_r;
    end
  end

  // scaling cells, shifts of 2^(NORM_N-1) down to 1
  atan2ti_pkg::ctrl_t n_ctrl [NORM_N+1];
  logic [MAG_W-1:0]   n_num  [NORM_N+1];
  logic [MAG_W-1:0]   n_den  [NORM_N+1];

  assign n_ctrl[0] = s1_ctrl_r;
  assign n_num[0]  = s1_num_r;
  assign n_den[0]  = s1_den_r;

  for (genvar i = 0; i < NORM_N; i++) begin : g_norm
    atan2ti_norm_cell #(
      .MAG_W (MAG_W),
      .SHIFT (1 << (NORM_N - 1 - i))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctrl_i (n_ctrl[i]),
      .num_i  (n_num[i]),
      .den_i  (n_den[i]),
      .ctrl_o (n_ctrl[i+1]),
      .num_o  (n_num[i+1]),
      .den_o  (n_den[i+1])
    );
  end

  logic [DW-1:0] num_s, den_s;

  if (MAG_W >= DW) begin : g_trunc
    assign num_s = n_num[NORM_N][DW-1:0];
    assign den_s = n_den[NORM_N][DW-1:0];
  end else begin : g_ext
    assign num_s = {{(DW - MAG_W){1'b0}}, n_num[NORM_N]};
    assign den_s = {{(DW - MAG_W){1'b0}}, n_den[NORM_N]};
  end

  // numerator times table steps and fraction scale
  atan2ti_pkg::ctrl_t m_ctrl_r;
  logic [PROD_W-1:0]  m_prod_r;
  logic [DW-1:0]      m_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctrl_r <= '0;
    end else if (adv) begin
      m_ctrl_r <= n_ctrl[NORM_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod_r <= PROD_W'(num_s) * PROD_W'(SCALE);
      m_den_r  <= den_s;
    end
  end

  // divider cells
  atan2ti_pkg::ctrl_t d_ctrl [QUO_W+1];
  logic [DW-1:0]      d_rem  [QUO_W+1];
  logic [QUO_W-1:0]   d_low  [QUO_W+1];
  logic [QUO_W-1:0]   d_quo  [QUO_W+1];
  logic [DW-1:0]      d_den  [QUO_W+1];

  assign d_ctrl[0] = m_ctrl_r;
  assign d_rem[0]  = m_prod_r[PROD_W-1:QUO_W];
  assign d_low[0]  = m_prod_r[QUO_W-1:0];
  assign d_quo[0]  = '0;
  assign d_den[0]  = m_den_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    atan2ti_div_cell #(
      .QUO_W (QUO_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctrl_i (d_ctrl[k]),
      .rem_i  (d_rem[k]),
      .low_i  (d_low[k]),
      .quo_i  (d_quo[k]),
      .den_i  (d_den[k]),
      .ctrl_o (d_ctrl[k+1]),
      .rem_o  (d_rem[k+1]),
      .low_o  (d_low[k+1]),
      .quo_o  (d_quo[k+1]),
      .den_o  (d_den[k+1])
    );
  end

  // table lookup stage
  logic [QUO_W-1:0]                    quo;
  logic [IDXQ_W-1:0]                   idx;
  logic [atan2ti_pkg::IDX_W-1:0]       idx_t;
  logic [EW-1:0]                       lo_ent, hi_ent, ent_diff;
  atan2ti_pkg::ctrl_t                  t_ctrl_r;
  logic [EW-1:0]                       t_lo_r;
  logic [atan2ti_pkg::DIFF_W-1:0]      t_diff_r;
  logic [FW-1:0]                       t_frac_r;
  logic                                t_last_r;

  assign quo      = d_quo[QUO_W];
  assign idx      = quo[QUO_W-1:FW];
  assign idx_t    = atan2ti_pkg::IDX_W'(idx);
  assign lo_ent   = atan2ti_pkg::atan_entry(idx_t);
  assign hi_ent   = atan2ti_pkg::atan_entry(idx_t + 1'b1);
  assign ent_diff = hi_ent - lo_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_ctrl_r <= '0;
    end else if (adv) begin
      t_ctrl_r <= d_ctrl[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_lo_r   <= lo_ent;
      t_diff_r <= ent_diff[atan2ti_pkg::DIFF_W-1:0];
      t_frac_r <= quo[FW-1:0];
      t_last_r <= idx >= IDXQ_W'(LAST_IDX);
    end
  end

  // interpolation and octant folding
  logic [atan2ti_pkg::DIFF_W+FW-1:0] step;
  logic [EW-1:0]                     oct;
  logic [EW:0]                       a_quad;
  logic [EW+1:0]                     a_half;
  logic [AW-1:0]                     a_full;
  logic [AW-1:0]                     angle_nxt;
  logic                              out_valid_r;
  logic [AW-1:0]                     out_angle_r;

  assign step   = t_diff_r * t_frac_r;
  assign oct    = t_last_r ?
                  atan2ti_pkg::atan_entry(atan2ti_pkg::IDX_W'(atan2ti_pkg::TBL_LEN - 1)) :
                  t_lo_r + EW'(step[atan2ti_pkg::DIFF_W+FW-1:FW]);
  assign a_quad = t_ctrl_r.fold.steep ?
                  (EW+1)'(atan2ti_pkg::QUARTER_TURN) - {1'b0, oct} : {1'b0, oct};
  assign a_half = t_ctrl_r.fold.xneg ?
                  (EW+2)'(atan2ti_pkg::HALF_TURN) - {1'b0, a_quad} : {1'b0, a_quad};
  assign a_full = t_ctrl_r.fold.yneg ? AW'(-{1'b0, a_half}) : AW'({1'b0, a_half});
  assign angle_nxt = t_ctrl_r.fold.zero ? '0 : a_full;

  assign adv = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= t_ctrl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_r <= angle_nxt;
    end
  end

  assign in_if.ready  = adv && rst_n;
  assign out_if.valid = out_valid_r;
  assign out_if.angle = out_angle_r;

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_angle_r) >= -12'sd1024 &&
                     $signed(out_angle_r) <= 12'sd1024))
    else $error("angle out of range");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_ctrl[QUO_W].valid && !d_ctrl[QUO_W].fold.zero |-> d_quo[QUO_W] <= QUO_W'(SCALE))
    else $error("quotient above full scale");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(t_ctrl_r) && $stable(out_angle_r) && $stable(t_lo_r))
    else $error("pipeline moved during stall");

  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    adv && t_ctrl_r.valid && t_ctrl_r.fold.zero |=> out_angle_r == '0)
    else $error("zero vector gave nonzero angle");
`endif

endmodule
